// ===== rtl/core/fcsg_pkg.sv =====
// Shared types and constants for the filled-circle span generator.
// No dependencies; used by every module of the block.
`default_nettype none

package fcsg_pkg;

  // Largest radius the block draws; larger commands are clamped to it.
  localparam logic [6:0] MAX_RADIUS = 7'd80;

  // A circle never produces more steps than this.
  localparam int unsigned STEP_LIMIT = 64;
  localparam int unsigned STEP_CNT_W = $clog2(STEP_LIMIT);
  localparam logic [STEP_CNT_W-1:0] STEP_CNT_LAST = STEP_CNT_W'(STEP_LIMIT - 1);

  // Midpoint decision arithmetic.
  localparam int unsigned DEC_W = 12;
  localparam logic signed [DEC_W-1:0] DEC_START = 12'sd3;
  localparam logic signed [DEC_W-1:0] DEC_DIAG  = 12'sd10;
  localparam logic signed [DEC_W-1:0] DEC_AXIS  = 12'sd6;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Widths of the stream words.
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 80;

  // A classified circle command, ready for the step engine.
  typedef struct packed {
    logic [7:0]              centre_x;
    logic [7:0]              centre_y;
    logic [6:0]              radius;
    logic signed [DEC_W-1:0] decision;
    logic [15:0]             colour;
  } cmd_t;

  // One set of four vertical spans.
  typedef struct packed {
    logic [15:0] span_colour;
    logic [7:0]  rows_far_bottom;
    logic [7:0]  rows_far_top;
    logic [7:0]  col_left_far;
    logic [7:0]  col_right_far;
    logic [7:0]  rows_near_bottom;
    logic [7:0]  rows_near_top;
    logic [7:0]  col_left_near;
    logic [7:0]  col_right_near;
  } span_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcsg_front.sv =====
// Front stage: takes circle commands, clamps the radius and prepares the
// starting decision value. Depends on fcsg_pkg.
`default_nettype none

module fcsg_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        centre_x,
  input  wire  [7:0]        centre_y,
  input  wire  [6:0]        radius,
  input  wire  [15:0]       colour,
  output logic              out_valid,
  input  wire               out_ready,
  output fcsg_pkg::cmd_t    out_cmd
);

  logic           valid;
  fcsg_pkg::cmd_t cmd;
  fcsg_pkg::cmd_t cmd_next;
  logic [6:0]     rad_sat;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_cmd   = cmd;

  always_comb begin
    rad_sat = (radius > fcsg_pkg::MAX_RADIUS) ? fcsg_pkg::MAX_RADIUS : radius;
    cmd_next.centre_x = centre_x;
    cmd_next.centre_y = centre_y;
    cmd_next.radius   = rad_sat;
    cmd_next.decision = fcsg_pkg::DEC_START
                      - $signed({{(fcsg_pkg::DEC_W-8){1'b0}}, rad_sat, 1'b0});
    cmd_next.colour   = colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fcsg_queue.sv =====
// Short command queue that lets the front and back stall independently.
// Depends on fcsg_pkg.
`default_nettype none

module fcsg_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  output logic              push_ready,
  input  fcsg_pkg::cmd_t    push_cmd,
  output logic              pop_valid,
  input  wire               pop,
  output fcsg_pkg::cmd_t    pop_cmd
);

  fcsg_pkg::cmd_t                 entries [fcsg_pkg::QUEUE_DEPTH];
  logic [fcsg_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [fcsg_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [fcsg_pkg::QUEUE_CNT_W-1:0] fill;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (fill != fcsg_pkg::QUEUE_CNT_W'(fcsg_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fcsg_back.sv =====
// Back stage: runs the midpoint circle loop for one command at a time and
// emits one set of spans per step through an output register. Depends on fcsg_pkg.
`default_nettype none

module fcsg_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               cmd_valid,
  output logic              cmd_pop,
  input  fcsg_pkg::cmd_t    cmd,
  output logic              out_valid,
  input  wire               out_ready,
  output fcsg_pkg::span_t   out_span,
  output logic              out_last
);

  logic                                busy;
  logic [7:0]                          cx;
  logic [7:0]                          cy;
  logic signed [7:0]                   step_x;
  logic signed [7:0]                   step_y;
  logic signed [fcsg_pkg::DEC_W-1:0]   decision;
  logic [15:0]                         pen_colour;
  logic [fcsg_pkg::STEP_CNT_W-1:0]     step_cnt;

  logic                                advance;
  logic signed [7:0]                   y_next;
  logic signed [7:0]                   x_next;
  logic signed [fcsg_pkg::DEC_W-1:0]   decision_next;
  logic signed [fcsg_pkg::DEC_W-1:0]   diff_ext;
  logic signed [fcsg_pkg::DEC_W-1:0]   x_ext;
  logic                                last_next;
  fcsg_pkg::span_t                     span_next;

  assign advance = busy && (!out_valid || out_ready);
  assign cmd_pop = !busy && cmd_valid;

  always_comb begin
    x_ext = fcsg_pkg::DEC_W'(step_x);
    if (decision > 0) begin
      y_next        = step_y - 8'sd1;
      diff_ext      = fcsg_pkg::DEC_W'(step_x) - fcsg_pkg::DEC_W'(step_y - 8'sd1);
      decision_next = decision + (diff_ext <<< 2) + fcsg_pkg::DEC_DIAG;
    end else begin
      y_next        = step_y;
      diff_ext      = '0;
      decision_next = decision + (x_ext <<< 2) + fcsg_pkg::DEC_AXIS;
    end
    x_next    = step_x + 8'sd1;
    last_next = (y_next < x_next) || (step_cnt == fcsg_pkg::STEP_CNT_LAST);

    span_next.col_right_near   = cx + step_x;
    span_next.col_left_near    = cx - step_x;
    span_next.rows_near_top    = cy - y_next;
    span_next.rows_near_bottom = cy + y_next;
    span_next.col_right_far    = cx + y_next;
    span_next.col_left_far     = cx - y_next;
    span_next.rows_far_top     = cy - step_x;
    span_next.rows_far_bottom  = cy + step_x;
    span_next.span_colour      = pen_colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      step_cnt  <= '0;
    end else begin
      if (cmd_pop) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (advance) begin
        busy     <= !last_next;
        step_cnt <= step_cnt + 1'b1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cx         <= cmd.centre_x;
      cy         <= cmd.centre_y;
      step_x     <= '0;
      step_y     <= $signed({1'b0, cmd.radius});
      decision   <= cmd.decision;
      pen_colour <= cmd.colour;
    end else if (advance) begin
      step_x   <= x_next;
      step_y   <= y_next;
      decision <= decision_next;
    end
    if (advance) begin
      out_span <= span_next;
      out_last <= last_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/filled_circle_span_generator.sv =====
// Top level of the filled-circle span generator: front stage, command queue
// and step engine. Depends on fcsg_pkg, fcsg_front, fcsg_queue and fcsg_back.
//
//   Channel | Direction | Handshake          | Contents
//   --------+-----------+--------------------+------------------------------------
//   s_*     | in        | s_tvalid/s_tready  | one circle command
//   m_*     | out       | m_tvalid/m_tready  | four vertical spans of one step
//
// A circle of radius r gives roughly r/sqrt(2)+1 items, never more than 64.
// The step engine produces one item per cycle while m_tready is high; a new
// circle first takes a load step, in which the engine takes its command from
// the queue and emits no item. The front stage and the two-entry queue
// take up to three further commands while a circle is being drawn. Reset
// is synchronous and clears all handshake state. A stalled m_tready freezes
// the engine and holds the output item until it is taken.
`default_nettype none

module filled_circle_span_generator (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // s_tdata, lowest bit up: centre_x[7:0], centre_y[15:8], radius[22:16],
  // colour[38:23], zero[39]
  input  wire  [fcsg_pkg::S_DATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // m_tdata, lowest bit up: col_right_near, col_left_near, rows_near_top,
  // rows_near_bottom, col_right_far, col_left_far, rows_far_top,
  // rows_far_bottom (8 bits each), span_colour (16 bits)
  output logic [fcsg_pkg::M_DATA_W-1:0]      m_tdata,
  output logic                               m_tlast
);

  logic            front_valid;
  logic            front_ready;
  fcsg_pkg::cmd_t  front_cmd;
  logic            queue_valid;
  logic            queue_pop;
  fcsg_pkg::cmd_t  queue_cmd;
  fcsg_pkg::span_t span;

  // Front stage: clamp the radius and work out the starting decision value.
  fcsg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .centre_x  (s_tdata[7:0]),
    .centre_y  (s_tdata[15:8]),
    .radius    (s_tdata[22:16]),
    .colour    (s_tdata[38:23]),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_cmd   (front_cmd)
  );

  // Commands wait here while the engine is drawing an earlier circle.
  fcsg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop        (queue_pop),
    .pop_cmd    (queue_cmd)
  );

  // Step engine: one midpoint step per accepted output item.
  fcsg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd_pop   (queue_pop),
    .cmd       (queue_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_span  (span),
    .out_last  (m_tlast)
  );

  // The span struct is declared highest field first, so it packs straight
  // into the output word with col_right_near in the lowest bits.
  assign m_tdata = span;

endmodule

`default_nettype wire

// ===== rtl/core/fcsg_checker.sv =====
// Port-level checks for the filled-circle span generator, bound to the top.
// Depends on fcsg_pkg and filled_circle_span_generator.
`default_nettype none

module fcsg_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           m_tvalid,
  input wire                           m_tready,
  input wire [fcsg_pkg::M_DATA_W-1:0]  m_tdata,
  input wire                           m_tlast
);

  logic [7:0] near_col_sum;
  logic [7:0] far_col_sum;
  logic [7:0] near_row_sum;
  logic [7:0] far_row_sum;

  // Mirrored columns and rows of one item share the centre, so their sums match.
  always_comb begin
    near_col_sum = m_tdata[7:0]   + m_tdata[15:8];
    far_col_sum  = m_tdata[39:32] + m_tdata[47:40];
    near_row_sum = m_tdata[23:16] + m_tdata[31:24];
    far_row_sum  = m_tdata[55:48] + m_tdata[63:56];
  end

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_column_symmetry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> near_col_sum == far_col_sum)
    else $error("span columns not symmetric about the centre");

  a_row_symmetry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> near_row_sum == far_row_sum)
    else $error("span rows not symmetric about the centre");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/filled_circle_span_generator_test.sv =====
// Self-checking testbench for filled_circle_span_generator: circle commands go in
// on the s_* stream and span items are checked against a local midpoint predictor.
// Depends on fcsg_pkg and the filled_circle_span_generator RTL.
`timescale 1ns / 100ps

module filled_circle_span_generator_test;

  // Run shape. The directed table comes first, then the random circles.
  localparam int RANDOM_CIRCLES = 446;
  localparam int QUIET_TAIL     = 60;   // last circles run with no idling at all
  localparam int HOLD_AFTER     = 60;   // circles sent before the long output hold
  localparam int HOLD_CYCLES    = 300;  // length of the long output hold
  localparam int DRAIN_AT       = 200;  // random circle before which the sender drains
  localparam int SETTLE_CYCLES  = 80;   // extra cycles watched once nothing is due
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no handshake before giving up
  localparam int REPORT_CAP     = 40;

  // One expected span item: the four spans plus the end-of-circle flag.
  typedef struct {
    fcsg_pkg::span_t spans;
    bit              last;
  } span_item_t;

  // One row of the directed plan. Rows with known_result set carry the single
  // span item they must produce, as coordinates packed in span_t order.
  typedef struct {
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [6:0]  rad;
    logic [15:0] colour;
    bit          known_result;
    logic [63:0] known_coords;
  } circle_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  wire                           s_tready;
  logic [fcsg_pkg::S_DATA_W-1:0] s_tdata = '0;
  wire                           m_tvalid;
  logic                          m_tready = 1'b0;
  wire  [fcsg_pkg::M_DATA_W-1:0] m_tdata;
  wire                           m_tlast;

  filled_circle_span_generator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected span items, oldest first, and the run bookkeeping.
  span_item_t spans_due[$];
  int         mismatches = 0;
  int         circles_sent = 0;
  int         spans_taken = 0;
  int         sender_gap_pct = 30;
  int         receiver_stall_pct = 30;
  bit         quiet_phase = 1'b0;
  bit         long_hold_done = 1'b0;
  int         idle_cycles = 0;

  // Predictor state: the latched command and the midpoint loop variables.
  logic [7:0]  hold_cx;
  logic [7:0]  hold_cy;
  logic [15:0] hold_colour;
  int          walk_x;
  int          walk_y;
  int          walk_d;

  // Walks the midpoint circle for one command and queues every span item it
  // gives. As in the block, the decision and y move before the spans are
  // formed, and all coordinates wrap to 8 bits.
  function automatic void trace_circle(logic [7:0] cx, logic [7:0] cy,
                                       logic [6:0] rad, logic [15:0] colour);
    int         clamped;
    int         steps;
    span_item_t item;
    clamped = (rad > fcsg_pkg::MAX_RADIUS) ? int'(fcsg_pkg::MAX_RADIUS) : int'(rad);
    hold_cx = cx;
    hold_cy = cy;
    hold_colour = colour;
    walk_x = 0;
    walk_y = clamped;
    walk_d = 3 - 2 * clamped;
    steps = 0;
    item.last = 1'b0;
    while (!item.last) begin
      if (walk_d > 0) begin
        walk_y = walk_y - 1;
        walk_d = walk_d + 4 * (walk_x - walk_y) + 10;
      end else begin
        walk_d = walk_d + 4 * walk_x + 6;
      end
      item.spans.col_right_near   = 8'(int'(hold_cx) + walk_x);
      item.spans.col_left_near    = 8'(int'(hold_cx) - walk_x);
      item.spans.rows_near_top    = 8'(int'(hold_cy) - walk_y);
      item.spans.rows_near_bottom = 8'(int'(hold_cy) + walk_y);
      item.spans.col_right_far    = 8'(int'(hold_cx) + walk_y);
      item.spans.col_left_far     = 8'(int'(hold_cx) - walk_y);
      item.spans.rows_far_top     = 8'(int'(hold_cy) - walk_x);
      item.spans.rows_far_bottom  = 8'(int'(hold_cy) + walk_x);
      item.spans.span_colour      = hold_colour;
      walk_x = walk_x + 1;
      steps = steps + 1;
      item.last = (walk_y < walk_x) || (steps >= int'(fcsg_pkg::STEP_LIMIT));
      spans_due.push_back(item);
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < REPORT_CAP) begin
      $display("%0t: span item %0d, %s is %0h, expected %0h",
               $realtime, spans_taken, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Offers one circle command and waits for it to be taken. s_tvalid is left
  // high so that a following command can go out back to back. The expected
  // span items are queued in the cycle that the command is accepted.
  task automatic send_circle(circle_row_t row);
    span_item_t item;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, row.colour, row.rad, row.cy, row.cx};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    if (row.known_result) begin
      item.spans = fcsg_pkg::span_t'({row.colour, row.known_coords});
      item.last  = 1'b1;
      spans_due.push_back(item);
    end else begin
      trace_circle(row.cx, row.cy, row.rad, row.colour);
    end
    circles_sent++;
  endtask

  // Drops s_tvalid for a burst of the given number of cycles.
  task automatic pause_sender(int cycles);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Result checker: every accepted span item is compared with the oldest one
  // that is due.
  always @(posedge clk) begin
    fcsg_pkg::span_t got;
    span_item_t      want;
    if (!rst && m_tvalid && m_tready) begin
      got = fcsg_pkg::span_t'(m_tdata);
      if (spans_due.size() == 0) begin
        report_mismatch("unexpected span item", got.col_right_near, 0);
      end else begin
        want = spans_due.pop_front();
        check_field("col_right_near", got.col_right_near, want.spans.col_right_near);
        check_field("col_left_near", got.col_left_near, want.spans.col_left_near);
        check_field("rows_near_top", got.rows_near_top, want.spans.rows_near_top);
        check_field("rows_near_bottom", got.rows_near_bottom,
                    want.spans.rows_near_bottom);
        check_field("col_right_far", got.col_right_far, want.spans.col_right_far);
        check_field("col_left_far", got.col_left_far, want.spans.col_left_far);
        check_field("rows_far_top", got.rows_far_top, want.spans.rows_far_top);
        check_field("rows_far_bottom", got.rows_far_bottom,
                    want.spans.rows_far_bottom);
        check_field("span_colour", got.span_colour, want.spans.span_colour);
        check_field("last_step", m_tlast, want.last);
      end
      spans_taken++;
    end
  end

  // Watchdog: a run in which nothing moves on either stream for too long has
  // hung, so it ends there.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Output side. m_tready stalls in random bursts, once holds off for a long
  // stretch so that the block fills up and stalls its input, and stays high
  // for the quiet tail of the run.
  initial begin
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!long_hold_done && circles_sent >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 99) < receiver_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, the directed plan, then random circles.
  initial begin
    circle_row_t plan[];
    circle_row_t row;

    // Rows with a known result: a zero radius gives one item with y at -1,
    // so its near rows and far columns wrap one step past the centre; a
    // radius of one collapses every span onto the centre. The other rows
    // cover the largest radius, clamping of oversized radii, the widest
    // radius codes and centres at the edges where spans wrap.
    plan = '{
      '{8'h00, 8'h00, 7'd0,   16'h0000, 1'b1, 64'h0000_01FF_FF01_0000},
      '{8'hFF, 8'hFF, 7'd0,   16'hFFFF, 1'b1, 64'hFFFF_00FE_FE00_FFFF},
      '{8'h80, 8'h40, 7'd1,   16'h1234, 1'b1, 64'h4040_8080_4040_8080},
      '{8'h12, 8'h34, 7'd0,   16'h8001, 1'b1, 64'h3434_1311_3335_1212},
      '{8'h40, 8'h40, 7'd2,   16'h0F0F, 1'b0, 64'h0},
      '{8'h10, 8'hF0, 7'd3,   16'hF0F0, 1'b0, 64'h0},
      '{8'h80, 8'h80, 7'd79,  16'h7E0F, 1'b0, 64'h0},
      '{8'h80, 8'h80, 7'd80,  16'hFFFF, 1'b0, 64'h0},
      '{8'h7F, 8'h7F, 7'd81,  16'h0001, 1'b0, 64'h0},
      '{8'h00, 8'h00, 7'd127, 16'h0000, 1'b0, 64'h0},
      '{8'hFF, 8'h00, 7'd64,  16'h8000, 1'b0, 64'h0},
      '{8'h01, 8'hFE, 7'd85,  16'h5555, 1'b0, 64'h0},
      '{8'hC0, 8'h20, 7'd42,  16'hAAAA, 1'b0, 64'h0},
      '{8'hFF, 8'hFF, 7'd5,   16'h5555, 1'b0, 64'h0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if ($urandom_range(0, 99) < sender_gap_pct) begin
        pause_sender($urandom_range(1, 11));
      end
      send_circle(plan[i]);
    end

    for (int n = 0; n < RANDOM_CIRCLES; n++) begin
      // Every forty circles the idling mix changes, so that some stretches
      // run flat out and others are full of gaps on one side or both.
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
          1: begin sender_gap_pct = 20; receiver_stall_pct = 10; end
          2: begin sender_gap_pct = 0;  receiver_stall_pct = 40; end
          default: begin sender_gap_pct = 60; receiver_stall_pct = 25; end
        endcase
      end
      quiet_phase = (n >= RANDOM_CIRCLES - QUIET_TAIL);

      if (n == DRAIN_AT) begin
        // Hold the input until every span item that is due has come out.
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (spans_due.size() != 0) begin
          @(negedge clk);
        end
      end else if (!quiet_phase && $urandom_range(0, 99) < sender_gap_pct) begin
        pause_sender($urandom_range(1, 11));
      end

      row.cx = 8'($urandom_range(0, 255));
      row.cy = 8'($urandom_range(0, 255));
      row.colour = 16'($urandom_range(0, 65535));
      row.known_result = 1'b0;
      row.known_coords = '0;
      // Mostly the full radius code range, with extra weight on tiny
      // circles and on the largest radius.
      case ($urandom_range(0, 9))
        0, 1, 2: row.rad = 7'($urandom_range(0, 10));
        3:       row.rad = fcsg_pkg::MAX_RADIUS;
        default: row.rad = 7'($urandom_range(0, 127));
      endcase
      send_circle(row);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (spans_due.size() != 0) begin
      @(posedge clk);
    end
    // Anything the block still emits now has no expectation and fails.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
